/* sv/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the pixel light shade unit.
// ----------------------------------------------------------------------------
package pls_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 2'd2;

	localparam logic [15:0] COEFF_RESET = 16'd655;

	// light constants, Q0.16 unless noted
	localparam logic [15:0] NIGHT_K        = 16'd328;
	localparam logic [15:0] DAY_C          = 16'd5898;
	localparam logic [15:0] NIGHT_MIN_WALL = 16'd6400;

	localparam int          TINT_W      = 17;
	localparam logic [TINT_W-1:0] TINT_RB = 17'd52429;
	localparam logic [TINT_W-1:0] TINT_G  = 17'd111411;
	localparam logic [7:0]  WHITE_LIMIT = 8'd200;
	localparam logic [7:0]  CH_MAX      = 8'd255;

	// divider denominators
	localparam int DST_DEN_W  = 33;
	localparam int COS_DEN_W  = 30;
	localparam int FALL_DEN_W = 45;
	localparam logic [DST_DEN_W-1:0]  DST_BASE  = 33'h0_0100_0000;
	localparam logic [FALL_DEN_W-1:0] FALL_BASE = 45'h0001_0000_0000;

	// cordic for the view direction, Q2.14
	localparam int CORDIC_W     = 18;
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START   = 18'sd9949;
	localparam logic signed [CORDIC_W-1:0] CORDIC_QUARTER = 18'sd16384;
	localparam logic signed [CORDIC_W-1:0] CORDIC_HALF    = 18'sd32768;
	localparam logic signed [CORDIC_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
		18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
	};

	typedef struct packed {
		logic zero;
		logic sat;
		logic neg;
	} cos_flag_t;

endpackage

/* sv/pls_if.sv */
// ----------------------------------------------------------------------------
// pls_if
// Pixel and shaded word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pls_pixel_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] ray_dir_x;
	logic signed [15:0] ray_dir_y;
	logic [15:0]        view_distance;
	logic [15:0]        wall_distance;
	logic [7:0]         texel_red;
	logic [7:0]         texel_green;
	logic [7:0]         texel_blue;
	logic [7:0]         texel_alpha;

	modport source (
		output valid, ray_dir_x, ray_dir_y, view_distance, wall_distance,
		output texel_red, texel_green, texel_blue, texel_alpha,
		input  ready
	);
	modport sink (
		input  valid, ray_dir_x, ray_dir_y, view_distance, wall_distance,
		input  texel_red, texel_green, texel_blue, texel_alpha,
		output ready
	);
endinterface

interface pls_shaded_if;
	logic        valid;
	logic        ready;
	logic [31:0] shaded_word;

	modport source (output valid, shaded_word, input ready);
	modport sink (input valid, shaded_word, output ready);
endinterface

/* sv/pls_delay.sv */
// ----------------------------------------------------------------------------
// pls_delay
// Fixed-length register line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module pls_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];
endmodule

/* sv/pls_sqrt.sv */
// ----------------------------------------------------------------------------
// pls_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module pls_sqrt #(
	parameter int IW = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IW-1:0]     x,
	output logic [IW/2-1:0]   root
);
	localparam int OW = IW / 2;

	logic [IW-1:0] x_q    [OW];
	logic [OW:0]   rem_q  [OW];
	logic [OW-1:0] root_q [OW];
	logic [IW-1:0] x_n    [OW];
	logic [OW:0]   rem_n  [OW];
	logic [OW-1:0] root_n [OW];

	always_comb begin : c_step
		logic [IW-1:0] xi;
		logic [OW:0]   ri;
		logic [OW-1:0] qi;
		logic [OW+2:0] t;
		logic [OW+2:0] trial;
		logic [OW+2:0] nxt;
		logic          ge;
		for (int j = 0; j < OW; j++) begin
			if (j == 0) begin
				xi = x;
				ri = '0;
				qi = '0;
			end else begin
				xi = x_q[j-1];
				ri = rem_q[j-1];
				qi = root_q[j-1];
			end
			t     = {ri, xi[IW-1:IW-2]};
			trial = {1'b0, qi, 2'b01};
			ge    = (t >= trial);
			nxt   = ge ? (t - trial) : t;
			x_n[j]    = xi << 2;
			rem_n[j]  = nxt[OW:0];
			root_n[j] = {qi[OW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < OW; j++) begin
				x_q[j]    <= x_n[j];
				rem_q[j]  <= rem_n[j];
				root_q[j] <= root_n[j];
			end
		end
	end

	assign root = root_q[OW-1];
endmodule

/* sv/pls_div.sv */
// ----------------------------------------------------------------------------
// pls_div
// Pipelined restoring divider: q = floor(a * 2^(QW-1) / d), needs a < 2*d.
// ----------------------------------------------------------------------------
module pls_div #(
	parameter int DW = 33,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q
);
	logic [DW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];
	logic [DW-1:0] rem_n [QW];
	logic [DW-1:0] den_n [QW];
	logic [QW-1:0] quo_n [QW];

	always_comb begin : c_step
		logic [DW:0]   t;
		logic [DW:0]   diff;
		logic [DW-1:0] di;
		logic [QW-1:0] qi;
		logic          ge;
		for (int j = 0; j < QW; j++) begin
			if (j == 0) begin
				t  = {1'b0, a};
				di = d;
				qi = '0;
			end else begin
				t  = {rem_q[j-1], 1'b0};
				di = den_q[j-1];
				qi = quo_q[j-1];
			end
			diff = t - {1'b0, di};
			ge   = (t >= {1'b0, di});
			// remainder stays below the divisor after every step
			rem_n[j] = ge ? diff[DW-1:0] : t[DW-1:0];
			den_n[j] = di;
			quo_n[j] = {qi[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QW; j++) begin
				rem_q[j] <= rem_n[j];
				den_q[j] <= den_n[j];
				quo_q[j] <= quo_n[j];
			end
		end
	end

	assign q = quo_q[QW-1];
endmodule

/* sv/pls_cordic.sv */
// ----------------------------------------------------------------------------
// pls_cordic
// Pipelined rotation cordic: cosine and sine of the view angle in Q2.14.
// ----------------------------------------------------------------------------
module pls_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic [15:0]                         angle,
	output logic signed [pls_pkg::CORDIC_W-1:0] cos_x,
	output logic signed [pls_pkg::CORDIC_W-1:0] sin_y
);
	import pls_pkg::*;

	logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0]    flip_q;
	logic signed [CORDIC_W-1:0] x_n [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_n [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_n [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0]    flip_n;

	always_comb begin : c_rot
		logic signed [CORDIC_W-1:0] xi, yi, zi, za, dx, dy;
		logic                       fi;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (i == 0) begin
				za = {{(CORDIC_W-16){angle[15]}}, angle};
				xi = CORDIC_START;
				yi = '0;
				zi = za;
				fi = 1'b0;
				// fold the back half-plane onto the front one
				if (za > CORDIC_QUARTER) begin
					zi = za - CORDIC_HALF;
					fi = 1'b1;
				end else if (za < -CORDIC_QUARTER) begin
					zi = za + CORDIC_HALF;
					fi = 1'b1;
				end
			end else begin
				xi = x_q[i-1];
				yi = y_q[i-1];
				zi = z_q[i-1];
				fi = flip_q[i-1];
			end
			dx = yi >>> i;
			dy = xi >>> i;
			if (!zi[CORDIC_W-1]) begin
				x_n[i] = xi - dx;
				y_n[i] = yi + dy;
				z_n[i] = zi - CORDIC_ATAN[i];
			end else begin
				x_n[i] = xi + dx;
				y_n[i] = yi - dy;
				z_n[i] = zi + CORDIC_ATAN[i];
			end
			if (i == CORDIC_STEPS - 1 && fi) begin
				x_n[i] = -x_n[i];
				y_n[i] = -y_n[i];
			end
			flip_n[i] = fi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				x_q[i] <= x_n[i];
				y_q[i] <= y_n[i];
				z_q[i] <= z_n[i];
			end
			flip_q <= flip_n;
		end
	end

	assign cos_x = x_q[CORDIC_STEPS-1];
	assign sin_y = y_q[CORDIC_STEPS-1];
endmodule

/* sv/pixel_light_shade_unit.sv */
// ----------------------------------------------------------------------------
// pixel_light_shade_unit
// Flashlight shading of one texel per beat with distance, angle and falloff.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and returns one packed RGBA word per pixel,
// in order. The pipeline depth is set by the longest path: the 16-stage cordic
// for the view direction, the product and magnitude stages, and the
// FRAC_BITS + 1 stage cosine divider in series. The whole pipeline holds
// while the output beat is not taken. Configuration writes are meant for
// an empty pipeline.
// ----------------------------------------------------------------------------
module pixel_light_shade_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_data,
	pls_pixel_if.sink                        pixel,
	pls_shaded_if.source                     shaded
);
	import pls_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int FW     = F + 1;
	localparam int AF_ST  = F + 22;
	localparam int LF_ST  = F + 24;
	localparam int VLD_N  = F + 26;
	localparam logic [FW-1:0] ONE = {1'b1, {F{1'b0}}};

	function automatic logic [7:0] sat8(input logic [9:0] v);
		return (v > {2'b00, CH_MAX}) ? CH_MAX : v[7:0];
	endfunction

	// configuration
	logic        night_q;
	logic [15:0] angle_q;
	logic [15:0] coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q <= 1'b0;
			angle_q <= '0;
			coeff_q <= COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NIGHT: night_q <= cfg_data[0];
				CFG_ANGLE: angle_q <= cfg_data[15:0];
				CFG_COEFF: coeff_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0] dst_k, fall_c;
	assign dst_k  = night_q ? NIGHT_K : coeff_q;
	assign fall_c = night_q ? coeff_q : DAY_C;

	// pipeline control
	logic             en;
	logic             out_valid_q;
	logic [VLD_N:1]   vld_q;

	assign en          = !out_valid_q || shaded.ready;
	assign pixel.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[VLD_N-1:1], pixel.valid};
			out_valid_q <= vld_q[VLD_N];
		end
	end

	// input beat
	logic signed [15:0] rx_s1, ry_s1;
	logic [15:0]        vd_s1, wd_s1;
	logic [23:0]        rgb_s1;
	logic [7:0]         alpha_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1    <= pixel.ray_dir_x;
			ry_s1    <= pixel.ray_dir_y;
			vd_s1    <= pixel.view_distance;
			wd_s1    <= pixel.wall_distance;
			rgb_s1   <= {pixel.texel_red, pixel.texel_green, pixel.texel_blue};
			alpha_s1 <= pixel.texel_alpha;
		end
	end

	// distance attenuation
	logic [DST_DEN_W-1:0] d1_s2;
	logic [31:0]          kv;
	logic [FW-1:0]        dst_q, dst_dly;

	assign kv = dst_k * vd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2 <= DST_BASE + {1'b0, kv};
		end
	end

	pls_div #(.DW(DST_DEN_W), .QW(FW)) u_div_dst (
		.clk(clk), .en(en), .a(DST_BASE), .d(d1_s2), .q(dst_q)
	);
	// meets the registered first light factor product, in the stage after the falloff
	pls_delay #(.W(FW), .N(20)) u_dly_dst (.clk(clk), .en(en), .d(dst_q), .q(dst_dly));

	// wall falloff: d^1.5 from d * floor(sqrt(d * 256))
	logic [15:0]           wdc_s2, wdc_dly;
	logic [11:0]           wsq;
	logic [27:0]           p_s15;
	logic [29:0]           pp_lo_s16, pp_hi_s16;
	logic [FALL_DEN_W-1:0] d3_s17;
	logic [FW-1:0]         fall_q, fall_dly;

	always_ff @(posedge clk) begin
		if (en) begin
			wdc_s2 <= (night_q && wd_s1 < NIGHT_MIN_WALL) ? NIGHT_MIN_WALL : wd_s1;
		end
	end

	pls_sqrt #(.IW(24)) u_sqrt_wall (.clk(clk), .en(en), .x({wdc_s2, 8'h00}), .root(wsq));
	pls_delay #(.W(16), .N(12)) u_dly_wdc (.clk(clk), .en(en), .d(wdc_s2), .q(wdc_dly));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s15     <= wdc_dly * wsq;
			// split product keeps each multiplier near 16 by 14
			pp_lo_s16 <= fall_c * p_s15[13:0];
			pp_hi_s16 <= fall_c * p_s15[27:14];
			d3_s17    <= FALL_BASE + {15'b0, pp_lo_s16} + {1'b0, pp_hi_s16, 14'b0};
		end
	end

	pls_div #(.DW(FALL_DEN_W), .QW(FW)) u_div_fall (
		.clk(clk), .en(en), .a(FALL_BASE), .d(d3_s17), .q(fall_q)
	);
	pls_delay #(.W(FW), .N(4)) u_dly_fall (.clk(clk), .en(en), .d(fall_q), .q(fall_dly));

	// angle factor
	logic signed [CORDIC_W-1:0] cx, sy;
	logic [31:0]                rxy_dly;
	logic signed [15:0]         rx_d, ry_d;
	logic [31:0]                sqx_s2, sqy_s2, msum_s3;
	logic [15:0]                mag;
	logic signed [33:0]         prx_s17, pry_s17;
	logic signed [34:0]         dot_s18;
	logic [34:0]                udot_s19;
	logic                       neg_s19;
	logic [COS_DEN_W-1:0]       ca_s20, cd_s20, cden;
	cos_flag_t                  flag_s20, flag_dly;
	logic [FW-1:0]              cos_q, cosm;
	logic [FW:0]                cos_sum;
	logic [FW-1:0]              cos_diff;
	logic [FW-1:0]              af_s21;

	pls_cordic u_cordic (.clk(clk), .en(en), .angle(angle_q), .cos_x(cx), .sin_y(sy));
	pls_delay #(.W(32), .N(15)) u_dly_ray (
		.clk(clk), .en(en), .d({rx_s1, ry_s1}), .q(rxy_dly)
	);
	assign rx_d = rxy_dly[31:16];
	assign ry_d = rxy_dly[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= 32'(rx_s1 * rx_s1);
			sqy_s2  <= 32'(ry_s1 * ry_s1);
			msum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	pls_sqrt #(.IW(32)) u_sqrt_mag (.clk(clk), .en(en), .x(msum_s3), .root(mag));

	assign cden = {mag, 14'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s17  <= rx_d * cx;
			pry_s17  <= ry_d * sy;
			dot_s18  <= {prx_s17[33], prx_s17} + {pry_s17[33], pry_s17};
			neg_s19  <= dot_s18[34];
			udot_s19 <= dot_s18[34] ? 35'(-dot_s18) : 35'(dot_s18);
			// a zero ray or a cosine at or past one skips the quotient
			flag_s20.zero <= (mag == '0);
			flag_s20.sat  <= (udot_s19 >= {5'b0, cden});
			flag_s20.neg  <= neg_s19;
			ca_s20 <= (mag == '0 || udot_s19 >= {5'b0, cden}) ? '0 : udot_s19[COS_DEN_W-1:0];
			cd_s20 <= cden;
		end
	end

	pls_div #(.DW(COS_DEN_W), .QW(FW)) u_div_cos (
		.clk(clk), .en(en), .a(ca_s20), .d(cd_s20), .q(cos_q)
	);
	pls_delay #(.W($bits(cos_flag_t)), .N(FW)) u_dly_flag (
		.clk(clk), .en(en), .d(flag_s20), .q(flag_dly)
	);

	assign cosm     = flag_dly.zero ? '0 : (flag_dly.sat ? ONE : cos_q);
	assign cos_sum  = {1'b0, ONE} + {1'b0, cosm};
	assign cos_diff = ONE - cosm;

	always_ff @(posedge clk) begin
		if (en) begin
			af_s21 <= flag_dly.neg ? {1'b0, cos_diff[F:1]} : cos_sum[FW:1];
		end
	end

	// light factor and channel scaling
	logic [2*FW-1:0] lf1_prod, lf_prod;
	logic [FW-1:0]   lf1_s22, lf_s23;
	logic [23:0]     rgb_dly;
	logic [7:0]      alpha_dly;
	logic [F+8:0]    cpr_s24, cpg_s24, cpb_s24;
	logic [F+25:0]   tr, tg, tb;
	logic [7:0]      r_s25, g_s25, b_s25;
	logic [31:0]     shaded_q;
	logic            white;

	pls_delay #(.W(24), .N(F + 23)) u_dly_rgb (.clk(clk), .en(en), .d(rgb_s1), .q(rgb_dly));
	pls_delay #(.W(8), .N(F + 25)) u_dly_alpha (
		.clk(clk), .en(en), .d(alpha_s1), .q(alpha_dly)
	);

	assign lf1_prod = af_s21 * fall_dly;
	assign lf_prod  = lf1_s22 * dst_dly;
	assign tr = cpr_s24 * TINT_RB;
	assign tg = cpg_s24 * TINT_G;
	assign tb = cpb_s24 * TINT_RB;
	assign white = night_q && r_s25 > WHITE_LIMIT && b_s25 > WHITE_LIMIT;

	always_ff @(posedge clk) begin
		if (en) begin
			lf1_s22 <= lf1_prod[2*F:F];
			lf_s23  <= lf_prod[2*F:F];
			cpr_s24 <= rgb_dly[23:16] * lf_s23;
			cpg_s24 <= rgb_dly[15:8] * lf_s23;
			cpb_s24 <= rgb_dly[7:0] * lf_s23;
			if (night_q) begin
				r_s25 <= sat8(tr[F+25:F+16]);
				g_s25 <= sat8(tg[F+25:F+16]);
				b_s25 <= sat8(tb[F+25:F+16]);
			end else begin
				r_s25 <= sat8({1'b0, cpr_s24[F+8:F]});
				g_s25 <= sat8({1'b0, cpg_s24[F+8:F]});
				b_s25 <= sat8({1'b0, cpb_s24[F+8:F]});
			end
			shaded_q <= white ? {CH_MAX, CH_MAX, CH_MAX, alpha_dly}
			                  : {r_s25, g_s25, b_s25, alpha_dly};
		end
	end

	assign shaded.valid       = out_valid_q;
	assign shaded.shaded_word = shaded_q;

	// factors never exceed one
	a_af_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[AF_ST] |-> (af_s21 <= ONE && fall_dly <= ONE))
		else $error("light factor above one");

	a_dst_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[AF_ST+1] |-> dst_dly <= ONE)
		else $error("distance factor above one");

	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LF_ST] |-> lf_s23 <= ONE)
		else $error("combined light factor above one");

	// white rule on the delivered word
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && night_q && shaded_q[31:24] > WHITE_LIMIT
			&& shaded_q[15:8] > WHITE_LIMIT) |-> shaded_q[23:16] == CH_MAX)
		else $error("night white rule broken");

	// a held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !shaded.ready) |=> (out_valid_q && $stable(shaded_q)))
		else $error("stalled result changed");
endmodule

/* verif/tb_pixel_light_shade_unit.sv */
// ----------------------------------------------------------------------------
// tb_pixel_light_shade_unit
// Self-checking bench for the flashlight shading unit. Pixels are driven
// through the valid/ready channel under several idle and stall mixes and
// register settings; every shaded word is compared in order with a word
// computed by an independent fixed-point shading calculation.
// ----------------------------------------------------------------------------
module tb_pixel_light_shade_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import pls_pkg::*;

	typedef struct {
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [15:0]        vd;
		logic [15:0]        wd;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} pixel_t;

	class shade_scoreboard;
		bit          night;
		bit [15:0]   angle;
		bit [15:0]   coeff;
		int          view_x;
		int          view_y;
		bit [31:0]   expected_words[$];
		int          mismatches;

		function new();
			night = 0;
			angle = 0;
			coeff = COEFF_RESET;
			mismatches = 0;
			update_view();
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] r;
			bit [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// view direction by cordic with half-turn reduction
		function void update_view();
			int atan_tab[16];
			int z;
			int x;
			int y;
			int dx;
			int dy;
			bit flip;
			atan_tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
				41, 20, 10, 5, 3, 1, 1, 0};
			z = int'(angle);
			x = 9949;
			y = 0;
			flip = 0;
			if (z >= 32768) z -= 65536;
			if (z > 16384) begin
				z -= 32768;
				flip = 1;
			end else if (z < -16384) begin
				z += 32768;
				flip = 1;
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_tab[i];
				end else begin
					x += dx;
					y -= dy;
					z += atan_tab[i];
				end
			end
			view_x = flip ? -x : x;
			view_y = flip ? -y : y;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_NIGHT: night = data[0];
				CFG_ANGLE: angle = data;
				CFG_COEFF: coeff = data;
				default: ;
			endcase
			update_view();
		endfunction

		function bit [31:0] shade(pixel_t p);
			longint    rx;
			longint    ry;
			longint    dot;
			bit [63:0] one;
			bit [63:0] k;
			bit [63:0] c;
			bit [63:0] dst;
			bit [63:0] mag;
			bit [63:0] udot;
			bit [63:0] cosm;
			bit [63:0] af;
			bit [63:0] wd;
			bit [63:0] fall;
			bit [63:0] lf;
			bit [63:0] ch[3];
			bit [63:0] tint_m;
			one = 64'd1 << 16;
			rx = longint'(p.rx);
			ry = longint'(p.ry);
			k = night ? 64'(NIGHT_K) : 64'(coeff);
			dst = (64'd1 << 40) / ((64'd1 << 24) + k * 64'(p.vd));
			if (dst > one) dst = one;

			dot = rx * view_x + ry * view_y;
			mag = int_sqrt(64'(rx * rx + ry * ry));
			udot = dot < 0 ? 64'(-dot) : 64'(dot);
			cosm = (mag == 0) ? 64'd0 : (udot << 16) / (mag << 14);
			if (cosm > one) cosm = one;
			af = dot < 0 ? (one - cosm) >> 1 : (one + cosm) >> 1;

			wd = 64'(p.wd);
			if (night && wd < 64'(NIGHT_MIN_WALL)) wd = 64'(NIGHT_MIN_WALL);
			c = night ? 64'(coeff) : 64'(DAY_C);
			fall = (64'd1 << 48) / ((64'd1 << 32) + c * (wd * int_sqrt(wd << 8)));

			lf = (af * fall) >> 16;
			lf = (lf * dst) >> 16;

			ch[0] = 64'(p.red);
			ch[1] = 64'(p.green);
			ch[2] = 64'(p.blue);
			for (int i = 0; i < 3; i++) begin
				if (night) begin
					tint_m = (i == 1) ? 64'(TINT_G) : 64'(TINT_RB);
					ch[i] = (ch[i] * lf * tint_m) >> 32;
				end else begin
					ch[i] = (ch[i] * lf) >> 16;
				end
				if (ch[i] > 255) ch[i] = 255;
			end
			if (night && ch[0] > WHITE_LIMIT && ch[2] > WHITE_LIMIT) begin
				ch[0] = 255;
				ch[1] = 255;
				ch[2] = 255;
			end
			return {ch[0][7:0], ch[1][7:0], ch[2][7:0], p.alpha};
		endfunction

		function void note_pixel(pixel_t p);
			expected_words.push_back(shade(p));
		endfunction

		function void check_word(bit [31:0] got);
			bit [31:0] want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected shaded word %08h", got);
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("shaded word mismatch: expected %08h actual %08h", want, got);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    idle_pct;
	int                    stall_pct;
	shade_scoreboard       sb;

	pls_pixel_if  pixel();
	pls_shaded_if shaded();

	pixel_light_shade_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel.sink),
		.shaded(shaded.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		shaded.ready <= ($urandom_range(99) >= stall_pct);
	end

	// inputs only change at rising edges, so the falling edge sees what the next edge takes
	always @(negedge clk) begin
		pixel_t p;
		if (arst_n && pixel.valid && pixel.ready) begin
			p.rx = pixel.ray_dir_x;
			p.ry = pixel.ray_dir_y;
			p.vd = pixel.view_distance;
			p.wd = pixel.wall_distance;
			p.red = pixel.texel_red;
			p.green = pixel.texel_green;
			p.blue = pixel.texel_blue;
			p.alpha = pixel.texel_alpha;
			sb.note_pixel(p);
		end
		if (arst_n && shaded.valid && shaded.ready)
			sb.check_word(shaded.shaded_word);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_pixel(pixel_t p);
		bit taken;
		pixel.valid <= 1'b1;
		pixel.ray_dir_x <= p.rx;
		pixel.ray_dir_y <= p.ry;
		pixel.view_distance <= p.vd;
		pixel.wall_distance <= p.wd;
		pixel.texel_red <= p.red;
		pixel.texel_green <= p.green;
		pixel.texel_blue <= p.blue;
		pixel.texel_alpha <= p.alpha;
		do begin
			@(negedge clk);
			taken = pixel.ready;
			@(posedge clk);
		end while (!taken);
		if ($urandom_range(99) < idle_pct) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic pixel_t make_pixel(logic signed [15:0] rx, logic signed [15:0] ry,
		logic [15:0] vd, logic [15:0] wd, logic [31:0] rgba);
		pixel_t p;
		p.rx = rx;
		p.ry = ry;
		p.vd = vd;
		p.wd = wd;
		{p.red, p.green, p.blue, p.alpha} = rgba;
		return p;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int kind;
		kind = $urandom_range(9);
		p = make_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		// bright beats: ray along the view, short distances, hot texels
		if (kind < 3) begin
			p.rx = 16'(sb.view_x + $signed($urandom_range(0, 200)) - 100);
			p.ry = 16'(sb.view_y + $signed($urandom_range(0, 200)) - 100);
			p.vd = 16'($urandom_range(0, 300));
			p.wd = 16'($urandom_range(0, 8000));
			p.red = 8'($urandom_range(200, 255));
			p.blue = 8'($urandom_range(200, 255));
		end else if (kind == 3) begin
			p.rx = '0;
			p.ry = '0;
		end else if (kind == 4) begin
			p.vd = 16'($urandom_range(0, 2000));
			p.wd = 16'($urandom_range(0, 2000));
		end else if (kind == 5) begin
			p.rx = 16'(-sb.view_x);
			p.ry = 16'(-sb.view_y);
		end
		return p;
	endfunction

	task automatic directed_pixels();
		push_pixel(make_pixel(16'sd16384, '0, '0, '0, 32'hFFFF_FFFF));
		push_pixel(make_pixel(-16'sd16384, '0, '0, '0, 32'hFFFF_FF00));
		push_pixel(make_pixel('0, '0, '0, '0, 32'hFFFF_FF80));
		push_pixel(make_pixel(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
		push_pixel(make_pixel(-16'sh8000, -16'sh8000, '0, 16'hFFFF, 32'h8080_8001));
		push_pixel(make_pixel('0, 16'sh7FFF, 16'hFFFF, '0, 32'h0000_0000));
		push_pixel(make_pixel('0, -16'sh8000, 16'd256, 16'd6399, 32'hC8C8_C8C8));
		push_pixel(make_pixel(16'sd9949, '0, '0, 16'd6400, 32'hC9FF_C9AA));
		push_pixel(make_pixel(16'sd1, '0, '0, 16'd1, 32'hFF00_FF55));
		push_pixel(make_pixel(16'sd1, 16'sd1, 16'd1, 16'd256, 32'h0102_0304));
		push_pixel(make_pixel(16'sh4000, -16'sh4000, 16'd6400, 16'd6401, 32'hF0F0_F0F0));
		push_pixel(make_pixel(-16'sd1, '0, '0, '0, 32'hFFFF_FFFF));
	endtask

	initial begin
		logic [15:0] night_set [6] = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0};
		logic [15:0] angle_set [6] = '{16'd0, 16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
		logic [15:0] coeff_set [6] = '{16'd655, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0};
		int idle_set [6] = '{0, 47, 0, 33, 47, 0};
		int stall_set [6] = '{0, 0, 47, 33, 47, 0};
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NIGHT;
		cfg_data = '0;
		pixel.valid = 1'b0;
		pixel.ray_dir_x = '0;
		pixel.ray_dir_y = '0;
		pixel.view_distance = '0;
		pixel.wall_distance = '0;
		pixel.texel_red = '0;
		pixel.texel_green = '0;
		pixel.texel_blue = '0;
		pixel.texel_alpha = '0;
		shaded.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) begin
				write_reg(CFG_NIGHT, night_set[ph]);
				write_reg(CFG_ANGLE, angle_set[ph]);
				write_reg(CFG_COEFF, coeff_set[ph]);
				idle_pct = idle_set[ph];
				stall_pct = stall_set[ph];
			end else begin
				write_reg(CFG_NIGHT, 16'($urandom_range(1)));
				write_reg(CFG_ANGLE, 16'($urandom));
				write_reg(CFG_COEFF,
					16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)));
				idle_pct = (ph == 6) ? 33 : 0;
				stall_pct = (ph == 6) ? 33 : 47;
			end
			if (ph < 2) directed_pixels();
			for (int n = 0; n < 125; n++) begin
				// hold off mid-phase until the pipeline is empty
				if (ph == 3 && n == 60) drain();
				push_pixel(random_pixel());
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
